>>> hdl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants for the best-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

	localparam int AMOUNT_W   = 16;
	localparam int BLOCK_W    = 4;
	localparam int BIU_W      = 5;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	// item kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_ALLOC = 1'b1;

	// register word index (paddr[2])
	localparam logic REG_BLOCKS_IN_USE = 1'b0;

	localparam logic [BIU_W-1:0] BIU_RESET = 5'd16;

	typedef struct packed {
		logic                kind;
		logic [BLOCK_W-1:0]  block_number;
		logic [AMOUNT_W-1:0] amount;
	} req_item_t;

	typedef struct packed {
		logic                granted;
		logic [BLOCK_W-1:0]  chosen_block;
		logic [AMOUNT_W-1:0] size_before;
	} rsp_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT,
		ST_RESULT
	} bfa_state_t;

endpackage

`default_nettype wire

>>> hdl/best_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// best_fit_block_allocator_core
// Best-fit allocator over a table of block free sizes, APB configured.
// ----------------------------------------------------------------------------
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  req      | req_valid, req_ready, req        | in
//  rsp      | rsp_valid, rsp_ready, rsp        | out
//  apb      | psel penable pwrite paddr pwdata | in, prdata/pready out
//
// A load item to a block in range writes the table as it is accepted.
// An allocate scans limit = min(blocks_in_use, NUMBER_OF_BLOCKS) blocks:
// one table RAM read per block feeds the single compare unit, then a drain,
// a charge write and the result. A zero blocks_in_use skips the scan.
// Reset clears the table through per-entry valid bits; no clearing pass.
// The result register lets a new item be accepted while a result waits;
// an allocate holds in its final state only if the previous result is unread.
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_block_allocator_core #(
	parameter int NUMBER_OF_BLOCKS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [bfa_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [bfa_pkg::APB_DATA_W-1:0]   pwdata,
	output      logic [bfa_pkg::APB_DATA_W-1:0]   prdata,
	output      logic                             pready,
	input  wire logic                             req_valid,
	output      logic                             req_ready,
	input  wire bfa_pkg::req_item_t               req,
	output      logic                             rsp_valid,
	input  wire logic                             rsp_ready,
	output      bfa_pkg::rsp_item_t               rsp
);

	import bfa_pkg::*;

	localparam int IW = $clog2(NUMBER_OF_BLOCKS);

	logic [BIU_W-1:0]    blocks_in_use;
	logic                ram_we;
	logic [IW-1:0]       ram_waddr;
	logic [AMOUNT_W-1:0] ram_wdata;
	logic                ram_re;
	logic [IW-1:0]       ram_raddr;
	logic [AMOUNT_W-1:0] ram_rdata;

	bfa_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.blocks_in_use (blocks_in_use)
	);

	bfa_ram #(
		.WIDTH (AMOUNT_W),
		.DEPTH (NUMBER_OF_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bfa_seq #(
		.NUMBER_OF_BLOCKS (NUMBER_OF_BLOCKS)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.blocks_in_use (blocks_in_use),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.rsp           (rsp),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata)
	);

endmodule

`default_nettype wire

>>> hdl/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/bfa_regs.sv
// ----------------------------------------------------------------------------
// bfa_regs
// APB register file holding the blocks_in_use setting.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [bfa_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [bfa_pkg::APB_DATA_W-1:0]   pwdata,
	output      logic [bfa_pkg::APB_DATA_W-1:0]   prdata,
	output      logic                             pready,
	output      logic [bfa_pkg::BIU_W-1:0]        blocks_in_use
);

	import bfa_pkg::*;

	logic [BIU_W-1:0] biu_q;
	logic             wr_en;
	logic             hit;

	assign hit    = (paddr[2] == REG_BLOCKS_IN_USE);
	assign wr_en  = psel & penable & pwrite & hit;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			biu_q <= BIU_RESET;
		end else if (wr_en) begin
			biu_q <= pwdata[BIU_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = {{(APB_DATA_W-BIU_W){1'b0}}, biu_q};
		end
	end

	assign blocks_in_use = biu_q;

endmodule

`default_nettype wire

>>> hdl/bfa_seq.sv
// ----------------------------------------------------------------------------
// bfa_seq
// Sequencer and shared compare unit: loads, best-fit scan, charge, result.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_seq #(
	parameter int NUMBER_OF_BLOCKS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [bfa_pkg::BIU_W-1:0]           blocks_in_use,
	input  wire logic                                req_valid,
	output      logic                                req_ready,
	input  wire bfa_pkg::req_item_t                  req,
	output      logic                                rsp_valid,
	input  wire logic                                rsp_ready,
	output      bfa_pkg::rsp_item_t                  rsp,
	// table RAM
	output      logic                                   ram_we,
	output      logic [$clog2(NUMBER_OF_BLOCKS)-1:0]    ram_waddr,
	output      logic [bfa_pkg::AMOUNT_W-1:0]           ram_wdata,
	output      logic                                   ram_re,
	output      logic [$clog2(NUMBER_OF_BLOCKS)-1:0]    ram_raddr,
	input  wire logic [bfa_pkg::AMOUNT_W-1:0]           ram_rdata
);

	import bfa_pkg::*;

	localparam int IW = $clog2(NUMBER_OF_BLOCKS);
	localparam int LW = ((IW + 1) > BIU_W) ? (IW + 1) : BIU_W;

	bfa_state_t state_q, state_d;

	logic [NUMBER_OF_BLOCKS-1:0] vld_q;
	logic [IW-1:0]               cnt_q;
	logic [IW-1:0]               last_q;
	logic [AMOUNT_W-1:0]         amt_q;

	logic                rd_v_s1;
	logic [IW-1:0]       idx_s1;
	logic                vld_s1;

	logic                found_q;
	logic [IW-1:0]       best_q;
	logic [AMOUNT_W-1:0] best_size_q;

	logic      rsp_valid_q;
	rsp_item_t rsp_q;

	logic                accept;
	logic                is_load;
	logic                load_ok;
	logic [LW-1:0]       limit;
	logic                limit_zero;
	logic [AMOUNT_W-1:0] cur_size;
	logic                take;
	logic                rsp_free;
	logic                rsp_load;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid & req_ready;
	assign is_load   = (req.kind == KIND_LOAD);
	assign load_ok   = (int'(req.block_number) < NUMBER_OF_BLOCKS);

	// search limit is min(blocks_in_use, table depth)
	assign limit = (int'(blocks_in_use) > NUMBER_OF_BLOCKS) ?
		LW'(NUMBER_OF_BLOCKS) : LW'(blocks_in_use);
	assign limit_zero = (blocks_in_use == '0);

	// shared compare unit
	assign cur_size = vld_s1 ? ram_rdata : '0;
	assign take = rd_v_s1 && (cur_size >= amt_q) &&
		(!found_q || (cur_size < best_size_q));

	assign rsp_free = !rsp_valid_q || rsp_ready;
	assign rsp_load = (state_q == ST_RESULT) && rsp_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !is_load) begin
					state_d = limit_zero ? ST_RESULT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == last_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_RESULT;
			ST_RESULT: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = IW'(req.block_number);
		ram_wdata = req.amount;
		if (state_q == ST_COMMIT) begin
			ram_we    = found_q;
			ram_waddr = best_q;
			ram_wdata = best_size_q - amt_q;
		end else if (accept && is_load) begin
			ram_we = load_ok;
		end
	end

	assign ram_re    = (state_q == ST_SCAN);
	assign ram_raddr = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vld_q       <= '0;
			cnt_q       <= '0;
			rd_v_s1     <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= (state_q == ST_SCAN);
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (accept) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (state_q == ST_SCAN) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			amt_q  <= req.amount;
			last_q <= IW'(limit - 1'b1);
		end
		idx_s1 <= cnt_q;
		vld_s1 <= vld_q[cnt_q];
		if (take) begin
			best_q      <= idx_s1;
			best_size_q <= cur_size;
		end
		if (rsp_load) begin
			rsp_q.granted      <= found_q;
			rsp_q.chosen_block <= found_q ? BLOCK_W'(best_q) : '0;
			rsp_q.size_before  <= found_q ? best_size_q : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
